[rtl/core/lpm_pkg.sv]
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the route table
// Holds the request and status codes and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none
package lpm_pkg;
    localparam int SLOTS   = 64;
    localparam int SLOT_W  = 6;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DEL    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } lpm_cmd_t;

    typedef struct packed {
        logic last;
    } lpm_sts_t;
endpackage
`default_nettype wire

[rtl/core/lpm_ctrl.sv]
// ----------------------------------------------------------------------------
// lpm_ctrl: request sequencer
// Load a request, scan all slots one a cycle, then finish and strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module lpm_ctrl
    import lpm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output lpm_cmd_t      cmd,
    input  wire lpm_sts_t sts
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.scan       = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.last)
                    state_next = S_DONE;
                else
                    cmd.scan = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // advance only on the last scanned slot; idx held in the datapath
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

[rtl/core/lpm_dp.sv]
// ----------------------------------------------------------------------------
// lpm_dp: slot memory, scan compare and update datapath
// One slot is read per cycle; the decision is applied after the scan.
// ----------------------------------------------------------------------------
`default_nettype none
module lpm_dp
    import lpm_pkg::*;
#(
    parameter int ROUTES_PER_FAMILY = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lpm_cmd_t    cmd,
    output lpm_sts_t         sts,
    input  wire logic [1:0]  req_type,
    input  wire logic        is_v6,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    input  wire logic        has_nexthop,
    input  wire logic [63:0] nexthop_hi,
    input  wire logic [63:0] nexthop_lo,
    input  wire logic [31:0] out_interface,
    input  wire logic [7:0]  admin_distance,
    input  wire logic [31:0] route_metric,
    output logic             strobe,
    output logic [1:0]       status,
    output logic [63:0]      match_prefix_hi,
    output logic [63:0]      match_prefix_lo,
    output logic [7:0]       match_len,
    output logic [63:0]      match_nexthop_hi,
    output logic [63:0]      match_nexthop_lo,
    output logic [31:0]      match_interface,
    output logic [7:0]       match_distance,
    output logic [31:0]      match_metric,
    output logic [31:0]      match_hits
);
    localparam int CNT_W = $clog2(ROUTES_PER_FAMILY + 1) > SLOT_W + 1 ?
                           $clog2(ROUTES_PER_FAMILY + 1) : SLOT_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ROUTES_PER_FAMILY);

    // route word stored per slot
    typedef struct packed {
        logic        fam;
        logic [63:0] phi;
        logic [63:0] plo;
        logic [7:0]  len;
        logic [63:0] nhi;
        logic [63:0] nlo;
        logic [31:0] oif;
        logic [7:0]  admin;
        logic [31:0] met;
        logic [31:0] hits;
    } route_t;

    route_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    route_t rd_reg;
    logic   rd_ok_reg;          // rd_reg holds a slot read by the scan
    logic [SLOT_W-1:0] rd_idx_reg;

    // latched request
    req_t         req_reg;
    logic         fam_reg;
    logic [63:0]  ahi_reg, alo_reg, nhi_reg, nlo_reg;
    logic [7:0]   len_reg;
    logic         hnh_reg;
    logic [31:0]  oif_reg, met_reg;
    logic [7:0]   dist_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic [CNT_W-1:0]  cnt4_reg, cnt6_reg;

    // scan results
    logic              hit_reg;       // exact match found / lookup candidate
    logic [SLOT_W-1:0] hit_idx_reg;
    route_t            best_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_idx_reg;

    logic [7:0] clamp_len;
    always_comb
    begin
        if (is_v6)
            clamp_len = (prefix_len > 8'd128) ? 8'd128 : prefix_len;
        else
            clamp_len = (prefix_len > 8'd32) ? 8'd32 : prefix_len;
    end

    // masks from stored length
    logic [127:0] mask;
    always_comb
    begin
        if (rd_reg.fam)
            mask = ~(128'(~128'd0) >> rd_reg.len);
        else
            mask = {96'd0, ~(32'hffff_ffff >> rd_reg.len[5:0]) |
                    {32{rd_reg.len[5]}}};
        if (!rd_reg.fam && rd_reg.len[5])
            mask = {96'd0, 32'hffff_ffff};
        if (rd_reg.fam && rd_reg.len[7])
            mask = '1;
    end

    logic rd_fam_ok, exact, contain, better;
    assign rd_fam_ok = rd_ok_reg && valid_reg[rd_idx_reg] && (rd_reg.fam == fam_reg);
    assign exact   = rd_fam_ok && rd_reg.len == len_reg &&
                     rd_reg.phi == ahi_reg && rd_reg.plo == alo_reg;
    assign contain = rd_fam_ok &&
                     ((({ahi_reg, alo_reg} ^ {rd_reg.phi, rd_reg.plo}) & mask) == '0);
    assign better  = !hit_reg || rd_reg.len > best_reg.len ||
                     (rd_reg.len == best_reg.len && rd_reg.admin < best_reg.admin);

    assign sts.last = rd_ok_reg && (rd_idx_reg == SLOT_W'(SLOTS - 1));

    // write port select
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    route_t            wr_data;
    logic [1:0]        st_next;
    logic              out_route;
    logic              set_v, clr_v;
    logic              full;

    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_data   = best_reg;
        st_next   = ST_NOTFOUND;
        out_route = 1'b0;
        set_v     = 1'b0;
        clr_v     = 1'b0;
        full      = fam_reg ? (cnt6_reg >= CNT_MAX) : (cnt4_reg >= CNT_MAX);
        unique case (req_reg)
            REQ_ADD:
            begin
                st_next = ST_OK;
                if (hit_reg)
                begin
                    if (dist_reg < best_reg.admin ||
                        (dist_reg == best_reg.admin && met_reg < best_reg.met))
                    begin
                        wr_en = 1'b1;
                        if (hnh_reg)
                        begin
                            wr_data.nhi = nhi_reg;
                            wr_data.nlo = nlo_reg;
                        end
                        wr_data.oif   = oif_reg;
                        wr_data.admin = dist_reg;
                        wr_data.met   = met_reg;
                    end
                end
                else if (full || !free_reg)
                    st_next = ST_FULL;
                else
                begin
                    wr_en   = 1'b1;
                    set_v   = 1'b1;
                    wr_idx  = free_idx_reg;
                    wr_data = '{fam: fam_reg, phi: ahi_reg, plo: alo_reg, len: len_reg,
                                nhi: hnh_reg ? nhi_reg : 64'd0,
                                nlo: hnh_reg ? nlo_reg : 64'd0,
                                oif: oif_reg, admin: dist_reg, met: met_reg,
                                hits: 32'd0};
                end
            end
            REQ_DEL:
            begin
                if (hit_reg)
                begin
                    st_next = ST_OK;
                    clr_v   = 1'b1;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit_reg)
                begin
                    st_next       = ST_OK;
                    out_route     = 1'b1;
                    wr_en         = 1'b1;
                    wr_data.hits  = best_reg.hits + 32'd1;
                end
            end
            default: st_next = ST_NOTFOUND;
        endcase
        if (!cmd.finish)
        begin
            wr_en = 1'b0;
            set_v = 1'b0;
            clr_v = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        rd_reg <= mem[idx_reg];
        if (cmd.load)
        begin
            req_reg  <= req_t'(req_type);
            fam_reg  <= is_v6;
            ahi_reg  <= is_v6 ? addr_hi : 64'd0;
            alo_reg  <= is_v6 ? addr_lo : {32'd0, addr_lo[31:0]};
            len_reg  <= clamp_len;
            hnh_reg  <= has_nexthop;
            nhi_reg  <= nexthop_hi;
            nlo_reg  <= nexthop_lo;
            oif_reg  <= out_interface;
            dist_reg <= admin_distance;
            met_reg  <= route_metric;
        end
        if (rd_ok_reg && !hit_reg)
        begin
            if ((req_reg == REQ_LOOKUP) ? contain : exact)
                best_reg <= rd_reg;
        end
        else if (rd_ok_reg && req_reg == REQ_LOOKUP && contain && better)
            best_reg <= rd_reg;
        rd_idx_reg <= idx_reg;
        match_prefix_hi  <= out_route ? best_reg.phi   : 64'd0;
        match_prefix_lo  <= out_route ? best_reg.plo   : 64'd0;
        match_len        <= out_route ? best_reg.len   : 8'd0;
        match_nexthop_hi <= out_route ? best_reg.nhi   : 64'd0;
        match_nexthop_lo <= out_route ? best_reg.nlo   : 64'd0;
        match_interface  <= out_route ? best_reg.oif   : 32'd0;
        match_distance   <= out_route ? best_reg.admin : 8'd0;
        match_metric     <= out_route ? best_reg.met   : 32'd0;
        match_hits       <= out_route ? best_reg.hits  : 32'd0;
        status           <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cnt4_reg     <= '0;
            cnt6_reg     <= '0;
            idx_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            strobe       <= 1'b0;
        end
        else
        begin
            strobe    <= cmd.finish;
            rd_ok_reg <= cmd.scan;
            if (cmd.scan)
                idx_reg <= idx_reg + SLOT_W'(1);
            if (cmd.load)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            if (rd_ok_reg)
            begin
                if (!valid_reg[rd_idx_reg] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if (req_reg == REQ_LOOKUP)
                begin
                    if (contain && better)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                end
                else if (exact && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
            end
            if (set_v)
            begin
                valid_reg[wr_idx] <= 1'b1;
                if (fam_reg)
                    cnt6_reg <= cnt6_reg + CNT_W'(1);
                else
                    cnt4_reg <= cnt4_reg + CNT_W'(1);
            end
            if (clr_v)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
                if (fam_reg && cnt6_reg != '0)
                    cnt6_reg <= cnt6_reg - CNT_W'(1);
                else if (!fam_reg && cnt4_reg != '0)
                    cnt4_reg <= cnt4_reg - CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/lpm_route_table.sv]
// ----------------------------------------------------------------------------
// lpm_route_table: longest prefix match route table, IPv4 and IPv6
// Add, delete and lookup over 64 shared slots by a linear scan.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | start / busy         | req_type .. route_metric
//  result   | strobe (one cycle)   | status, match_*
//
// The request is latched at the accepting edge. 64 slot reads follow, one a
// cycle from the single read port of the slot memory; then the last slot is
// compared, the update is applied and the result registered, and the strobe
// is high in the cycle after the update. busy is high from the cycle after the
// accepting edge until the strobe cycle, so a new request is taken only once
// the last one is through; results cannot be stalled.
// Reset clears the valid bits and family counts at once.
// ----------------------------------------------------------------------------
`default_nettype none
module lpm_route_table
    import lpm_pkg::*;
#(
    parameter int ROUTES_PER_FAMILY = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic        is_v6,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    input  wire logic        has_nexthop,
    input  wire logic [63:0] nexthop_hi,
    input  wire logic [63:0] nexthop_lo,
    input  wire logic [31:0] out_interface,
    input  wire logic [7:0]  admin_distance,
    input  wire logic [31:0] route_metric,
    output logic             strobe,
    output logic [1:0]       status,
    output logic [63:0]      match_prefix_hi,
    output logic [63:0]      match_prefix_lo,
    output logic [7:0]       match_len,
    output logic [63:0]      match_nexthop_hi,
    output logic [63:0]      match_nexthop_lo,
    output logic [31:0]      match_interface,
    output logic [7:0]       match_distance,
    output logic [31:0]      match_metric,
    output logic [31:0]      match_hits
);
    lpm_cmd_t cmd;
    lpm_sts_t sts;
    logic     ctrl_busy;

    // request accepted when start meets an idle controller
    lpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctrl_busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    assign busy = ctrl_busy;

    lpm_dp #(.ROUTES_PER_FAMILY(ROUTES_PER_FAMILY)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .req_type         (req_type),
        .is_v6            (is_v6),
        .addr_hi          (addr_hi),
        .addr_lo          (addr_lo),
        .prefix_len       (prefix_len),
        .has_nexthop      (has_nexthop),
        .nexthop_hi       (nexthop_hi),
        .nexthop_lo       (nexthop_lo),
        .out_interface    (out_interface),
        .admin_distance   (admin_distance),
        .route_metric     (route_metric),
        .strobe           (strobe),
        .status           (status),
        .match_prefix_hi  (match_prefix_hi),
        .match_prefix_lo  (match_prefix_lo),
        .match_len        (match_len),
        .match_nexthop_hi (match_nexthop_hi),
        .match_nexthop_lo (match_nexthop_lo),
        .match_interface  (match_interface),
        .match_distance   (match_distance),
        .match_metric     (match_metric),
        .match_hits       (match_hits)
    );
endmodule
`default_nettype wire

[tb/sv/lpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_checker: route table scoreboard
// Watches the request and result channels of lpm_route_table. It keeps its
// own copy of the route slots, works out the result of each accepted request
// and compares every strobed result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module lpm_checker
    import lpm_pkg::*;
#(
    parameter int ROUTES_PER_FAMILY = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  req_type,
    input  wire logic        is_v6,
    input  wire logic [63:0] addr_hi,
    input  wire logic [63:0] addr_lo,
    input  wire logic [7:0]  prefix_len,
    input  wire logic        has_nexthop,
    input  wire logic [63:0] nexthop_hi,
    input  wire logic [63:0] nexthop_lo,
    input  wire logic [31:0] out_interface,
    input  wire logic [7:0]  admin_distance,
    input  wire logic [31:0] route_metric,
    input  wire logic        strobe,
    input  wire logic [1:0]  status,
    input  wire logic [63:0] match_prefix_hi,
    input  wire logic [63:0] match_prefix_lo,
    input  wire logic [7:0]  match_len,
    input  wire logic [63:0] match_nexthop_hi,
    input  wire logic [63:0] match_nexthop_lo,
    input  wire logic [31:0] match_interface,
    input  wire logic [7:0]  match_distance,
    input  wire logic [31:0] match_metric,
    input  wire logic [31:0] match_hits,
    output int               failures,
    output int               outstanding
);
    typedef struct packed {
        status_t      st;
        logic [127:0] pfx;
        logic [7:0]   len;
        logic [127:0] nh;
        logic [31:0]  oif;
        logic [7:0]   admin;
        logic [31:0]  met;
        logic [31:0]  hits;
    } route_result_t;

    route_result_t results_due[$];

    logic         rt_valid [SLOTS];
    logic         rt_v6    [SLOTS];
    logic [127:0] rt_pfx   [SLOTS];
    logic [7:0]   rt_len   [SLOTS];
    logic [127:0] rt_nh    [SLOTS];
    logic [31:0]  rt_oif   [SLOTS];
    logic [7:0]   rt_dist  [SLOTS];
    logic [31:0]  rt_met   [SLOTS];
    logic [31:0]  rt_hits  [SLOTS];
    int           routes_v4;
    int           routes_v6;

    function automatic logic [127:0] net_mask(logic v6, logic [7:0] len);
        if (len == 0)
            return '0;
        if (v6)
            return ~128'd0 << (128 - len);
        return {96'd0, 32'hffff_ffff << (32 - len)};
    endfunction

    function automatic int exact_slot(logic v6, logic [127:0] a, logic [7:0] len);
        for (int i = 0; i < SLOTS; i++)
            if (rt_valid[i] && rt_v6[i] == v6 && rt_len[i] == len && rt_pfx[i] == a)
                return i;
        return -1;
    endfunction

    // Apply one request to the slot copy and return the result it produces.
    function automatic route_result_t route_request(
        logic [1:0] rq, logic v6, logic [127:0] raw_addr, logic [7:0] raw_len,
        logic hn, logic [127:0] nh, logic [31:0] oif, logic [7:0] ad,
        logic [31:0] met);
        route_result_t r;
        logic [127:0]  a;
        logic [7:0]    len;
        int            s;
        r = '0;
        a = v6 ? raw_addr : {96'd0, raw_addr[31:0]};
        len = raw_len;
        if (v6 && len > 128)
            len = 128;
        if (!v6 && len > 32)
            len = 32;
        case (req_t'(rq))
            REQ_ADD:
            begin
                r.st = ST_OK;
                s = exact_slot(v6, a, len);
                if (s >= 0)
                begin
                    // replace only on a better distance, or same distance and lower metric
                    if (ad < rt_dist[s] || (ad == rt_dist[s] && met < rt_met[s]))
                    begin
                        if (hn)
                            rt_nh[s] = nh;
                        rt_oif[s] = oif;
                        rt_dist[s] = ad;
                        rt_met[s] = met;
                    end
                end
                else
                begin
                    s = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!rt_valid[i])
                            s = i;
                    if ((v6 ? routes_v6 : routes_v4) >= ROUTES_PER_FAMILY || s < 0)
                        r.st = ST_FULL;
                    else
                    begin
                        rt_valid[s] = 1'b1;
                        rt_v6[s] = v6;
                        rt_pfx[s] = a;
                        rt_len[s] = len;
                        rt_nh[s] = hn ? nh : '0;
                        rt_oif[s] = oif;
                        rt_dist[s] = ad;
                        rt_met[s] = met;
                        rt_hits[s] = '0;
                        if (v6)
                            routes_v6++;
                        else
                            routes_v4++;
                    end
                end
            end
            REQ_DEL:
            begin
                s = exact_slot(v6, a, len);
                if (s < 0)
                    r.st = ST_NOTFOUND;
                else
                begin
                    r.st = ST_OK;
                    rt_valid[s] = 1'b0;
                    if (v6 && routes_v6 > 0)
                        routes_v6--;
                    if (!v6 && routes_v4 > 0)
                        routes_v4--;
                end
            end
            REQ_LOOKUP:
            begin
                s = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!rt_valid[i] || rt_v6[i] != v6)
                        continue;
                    if (((a ^ rt_pfx[i]) & net_mask(v6, rt_len[i])) != 0)
                        continue;
                    if (s < 0 || rt_len[i] > rt_len[s] ||
                        (rt_len[i] == rt_len[s] && rt_dist[i] < rt_dist[s]))
                        s = i;
                end
                if (s < 0)
                    r.st = ST_NOTFOUND;
                else
                begin
                    r.st = ST_OK;
                    r.pfx = rt_pfx[s];
                    r.len = rt_len[s];
                    r.nh = rt_nh[s];
                    r.oif = rt_oif[s];
                    r.admin = rt_dist[s];
                    r.met = rt_met[s];
                    r.hits = rt_hits[s];
                    rt_hits[s] = rt_hits[s] + 32'd1;
                end
            end
            default:
                r.st = ST_NOTFOUND;
        endcase
        return r;
    endfunction

    function automatic int field_diff(string name, logic [127:0] want, logic [127:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        route_result_t w;
        int            bad;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                rt_valid[i] = 1'b0;
            routes_v4 = 0;
            routes_v6 = 0;
            results_due.delete();
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result strobed with none due, status %0d", $time, status);
                    failures++;
                end
                else
                begin
                    w = results_due.pop_front();
                    bad = field_diff("status", w.st, status)
                        + field_diff("match_prefix", w.pfx, {match_prefix_hi, match_prefix_lo})
                        + field_diff("match_len", w.len, match_len)
                        + field_diff("match_nexthop", w.nh,
                                     {match_nexthop_hi, match_nexthop_lo})
                        + field_diff("match_interface", w.oif, match_interface)
                        + field_diff("match_distance", w.admin, match_distance)
                        + field_diff("match_metric", w.met, match_metric)
                        + field_diff("match_hits", w.hits, match_hits);
                    if (bad != 0)
                        failures++;
                end
            end
            if (start && !busy)
                results_due.push_back(route_request(req_type, is_v6, {addr_hi, addr_lo},
                    prefix_len, has_nexthop, {nexthop_hi, nexthop_lo}, out_interface,
                    admin_distance, route_metric));
            outstanding = results_due.size();
        end
    end
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: route table testbench
// Drives add, delete, lookup and REQ_NONE requests into lpm_route_table, first a
// directed set around defaults, host routes, replacement and clamping, then
// random requests over a pool of nested routes that fills each family.
// ----------------------------------------------------------------------------
module tb;
    import lpm_pkg::*;

    localparam int POOL = 40;   // route keys per family, more than fit

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic        has_nexthop;
    logic [63:0] nexthop_hi;
    logic [63:0] nexthop_lo;
    logic [31:0] out_interface;
    logic [7:0]  admin_distance;
    logic [31:0] route_metric;
    logic        strobe;
    logic [1:0]  status;
    logic [63:0] match_prefix_hi;
    logic [63:0] match_prefix_lo;
    logic [7:0]  match_len;
    logic [63:0] match_nexthop_hi;
    logic [63:0] match_nexthop_lo;
    logic [31:0] match_interface;
    logic [7:0]  match_distance;
    logic [31:0] match_metric;
    logic [31:0] match_hits;
    int          failures;
    int          outstanding;

    // route keys: family, full address and raw (unclamped) length
    logic [127:0] key_addr [2][POOL];
    logic [7:0]   key_len  [2][POOL];

    lpm_route_table uut (.*);
    lpm_checker chk (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [127:0] keep_mask(logic v6, logic [7:0] len);
        if (len == 0)
            return '0;
        if (v6)
            return (len >= 128) ? ~128'd0 : ~128'd0 << (128 - len);
        return (len >= 32) ? {96'd0, 32'hffff_ffff} : {96'd0, 32'hffff_ffff << (32 - len)};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 90)
            return $urandom_range(1, 5);
        return $urandom_range(20, 90);
    endfunction

    // Present one request and hold it until the block accepts it.
    task automatic send(req_t rq, logic v6, logic [127:0] a, logic [7:0] len, logic hn,
                        logic [127:0] nh, logic [31:0] oif, logic [7:0] ad,
                        logic [31:0] met);
        int gap;
        req_type <= rq;
        is_v6 <= v6;
        {addr_hi, addr_lo} <= a;
        prefix_len <= len;
        has_nexthop <= hn;
        {nexthop_hi, nexthop_lo} <= nh;
        out_interface <= oif;
        admin_distance <= ad;
        route_metric <= met;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge; drop start only when a gap follows
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_add(logic v6, logic [127:0] a, logic [7:0] len);
        logic [7:0]  ad;
        logic [31:0] met;
        // narrow distances and metrics so replacements and ties turn up
        ad = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        met = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        send(REQ_ADD, v6, a, len, 1'($urandom_range(0, 1)), rand128(), $urandom, ad, met);
    endtask

    initial
    begin
        logic [127:0] base [2][4];
        logic [127:0] m;
        logic [127:0] a;
        int           f;
        int           k;
        int           p;

        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_NONE;
        is_v6 = 1'b0;
        addr_hi = '0;
        addr_lo = '0;
        prefix_len = '0;
        has_nexthop = 1'b0;
        nexthop_hi = '0;
        nexthop_lo = '0;
        out_interface = '0;
        admin_distance = '0;
        route_metric = '0;

        // Build nested route keys: each shares one of a few bases above its length.
        for (f = 0; f < 2; f++)
        begin
            base[f][0] = '0;
            base[f][1] = ~128'd0;
            base[f][2] = rand128();
            base[f][3] = rand128();
            for (k = 0; k < POOL; k++)
            begin
                key_len[f][k] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                              : 8'($urandom_range(0, f ? 128 : 32));
                m = keep_mask(1'(f), key_len[f][k]);
                key_addr[f][k] = (base[f][$urandom_range(0, 3)] & m) | (rand128() & ~m);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, defaults, host routes, replacement rules, clamping.
        send(REQ_LOOKUP, 1'b1, '0, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_LOOKUP, 1'b0, {96'd0, 32'h0a01_0203}, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_ADD, 1'b0, '0, 8'd0, 1'b1, 128'h1, 32'd1, 8'd255, 32'hffff_ffff);
        send(REQ_ADD, 1'b0, ~128'd0, 8'd32, 1'b0, ~128'd0, 32'hffff_ffff, 8'd0, 32'd0);
        send(REQ_ADD, 1'b0, {96'd0, 32'h0a00_0000}, 8'd8, 1'b1, 128'h5, 32'd7, 8'd20, 32'd10);
        send(REQ_LOOKUP, 1'b0, {96'd0, 32'h0a01_0203}, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_LOOKUP, 1'b0, ~128'd0, 8'd0, 1'b0, '0, '0, '0, '0);
        // worse distance: nothing changes
        send(REQ_ADD, 1'b0, {96'd0, 32'h0a00_0000}, 8'd8, 1'b1, 128'h9, 32'd8, 8'd30, 32'd0);
        // lower distance without next hop: next hop kept
        send(REQ_ADD, 1'b0, {96'd0, 32'h0a00_0000}, 8'd8, 1'b0, 128'h9, 32'd9, 8'd10, 32'd50);
        // same distance, lower metric
        send(REQ_ADD, 1'b0, {96'd0, 32'h0a00_0000}, 8'd8, 1'b1, 128'hb, 32'd3, 8'd10, 32'd4);
        send(REQ_LOOKUP, 1'b0, {96'd0, 32'h0aff_ffff}, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_DEL, 1'b0, {96'd0, 32'h0b00_0000}, 8'd8, 1'b0, '0, '0, '0, '0);
        send(REQ_DEL, 1'b0, {96'd0, 32'h0a00_0000}, 8'd8, 1'b0, '0, '0, '0, '0);
        send(REQ_LOOKUP, 1'b0, {96'd0, 32'h0a01_0203}, 8'd0, 1'b0, '0, '0, '0, '0);
        // over-long prefixes clamp to the family maximum
        send(REQ_ADD, 1'b0, {96'd0, 32'hc0a8_0101}, 8'd255, 1'b1, ~128'd0, 32'd2, 8'd1, 32'd1);
        send(REQ_DEL, 1'b0, {96'd0, 32'hc0a8_0101}, 8'd32, 1'b0, '0, '0, '0, '0);
        send(REQ_ADD, 1'b1, ~128'd0, 8'd200, 1'b1, rand128(), 32'd4, 8'd0, 32'd0);
        send(REQ_ADD, 1'b1, '0, 8'd0, 1'b0, '0, 32'd5, 8'd255, 32'hffff_ffff);
        send(REQ_LOOKUP, 1'b1, ~128'd0, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_LOOKUP, 1'b1, ~128'd0, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_LOOKUP, 1'b1, 128'h1, 8'd0, 1'b0, '0, '0, '0, '0);
        send(REQ_NONE, 1'b1, rand128(), 8'd64, 1'b1, rand128(), $urandom, 8'd3, $urandom);

        // Random: pool keys so the table fills, replaces and refuses.
        repeat (1030)
        begin
            f = $urandom_range(0, 1);
            k = $urandom_range(0, POOL - 1);
            p = $urandom_range(0, 99);
            if (p < 45)
                send_random_add(1'(f), key_addr[f][k], key_len[f][k]);
            else if (p < 60)
                send(REQ_DEL, 1'(f), key_addr[f][k], key_len[f][k],
                     1'($urandom_range(0, 1)), rand128(), $urandom, 8'($urandom), $urandom);
            else if (p < 97)
            begin
                // destination inside a pool route, now and then anywhere
                m = keep_mask(1'(f), key_len[f][k]);
                a = (key_addr[f][k] & m) | (rand128() & ~m);
                if ($urandom_range(0, 6) == 0)
                    a = rand128();
                send(REQ_LOOKUP, 1'(f), a, 8'($urandom), 1'($urandom_range(0, 1)), rand128(),
                     $urandom, 8'($urandom), $urandom);
            end
            else
                send(REQ_NONE, 1'(f), rand128(), 8'($urandom), 1'($urandom_range(0, 1)),
                     rand128(), $urandom, 8'($urandom), $urandom);
        end

        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/core/lpm_pkg.sv
rtl/core/lpm_ctrl.sv
rtl/core/lpm_dp.sv
rtl/core/lpm_route_table.sv
tb/sv/lpm_checker.sv
tb/sv/tb.sv
